// File: hdl/hsd_pkg.sv
// Shared types, constants and decode functions for the Hamming (7,4) stream decoder.
package hsd_pkg;

    localparam int HSD_CW_BITS          = 7;
    localparam int HSD_GATHER_BITS      = 6;
    localparam int HSD_ERROR_COUNT_BITS = 32;
    localparam int HSD_QUEUE_DEPTH      = 2;
    localparam int HSD_TOTAL_BITS       = 32;

    // One input beat after bit gathering: one or two whole codewords, or an end marker.
    typedef struct packed {
        logic [HSD_CW_BITS-1:0] cw0;
        logic [HSD_CW_BITS-1:0] cw1;
        logic                   two;
        logic                   is_end;
    } t_work;

    typedef struct packed {
        logic [7:0]                out_byte;
        logic [HSD_TOTAL_BITS-1:0] error_total;
        logic                      is_summary;
    } t_result;

    // Column j of the parity matrix is j+1; c0 sits in the codeword MSB.
    function automatic logic [2:0] hsd_syndrome(input logic [HSD_CW_BITS-1:0] cw);
        logic [2:0] s;
        s = 3'd0;
        for (int j = 0; j < HSD_CW_BITS; j++) begin
            if (cw[HSD_CW_BITS-1-j]) begin
                s = s ^ 3'(j + 1);
            end
        end
        return s;
    endfunction

    // Syndromes 1 to 4 point at a data bit; the rest leave the data alone.
    function automatic logic [3:0] hsd_correct(input logic [HSD_CW_BITS-1:0] cw);
        logic [2:0] s;
        logic [3:0] nib;
        s   = hsd_syndrome(cw);
        nib = cw[6:3];
        case (s)
            3'd1:    nib = nib ^ 4'b1000;
            3'd2:    nib = nib ^ 4'b0100;
            3'd3:    nib = nib ^ 4'b0010;
            3'd4:    nib = nib ^ 4'b0001;
            default: nib = nib;
        endcase
        return nib;
    endfunction

endpackage

// File: hdl/hsd_fifo.sv
// Small synchronous queue with combinational read of the head entry.
module hsd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

endmodule

// File: hdl/hsd_front.sv
// Front end: gathers stream bits and cuts whole 7-bit codewords out of each beat.
module hsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_data,
    output hsd_pkg::t_work o_work
);
    import hsd_pkg::*;

    localparam int ALL_BITS = HSD_GATHER_BITS + 8;

    logic [HSD_GATHER_BITS-1:0] r_gather, n_gather;
    logic [2:0]                 r_held, n_held;
    logic [ALL_BITS-1:0]        w_all;
    logic [ALL_BITS-1:0]        w_shifted;
    logic                       w_two;

    assign w_all     = {r_gather, i_data_byte};
    assign w_two     = (r_held == 3'd6);
    // The first codeword starts at the oldest held bit.
    assign w_shifted = w_all >> ({1'b0, r_held} + 4'd1);

    always_comb begin
        o_work.is_end = i_end_of_data;
        o_work.two    = w_two;
        o_work.cw0    = w_two ? w_all[13:7] : w_shifted[HSD_CW_BITS-1:0];
        o_work.cw1    = w_all[6:0];

        n_gather = r_gather;
        n_held   = r_held;
        if (i_accept) begin
            if (i_end_of_data) begin
                n_held = 3'd0;
            end else if (w_two) begin
                n_held = 3'd0;
            end else begin
                // Keep the low bits left over after the codeword.
                n_gather = w_all[HSD_GATHER_BITS-1:0];
                n_held   = r_held + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather <= '0;
            r_held   <= '0;
        end else begin
            r_gather <= n_gather;
            r_held   <= n_held;
        end
    end

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 3'd6)
        else $error("held bit count out of range");

    a_two_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_end_of_data && r_held == 3'd6) |=> (r_held == 3'd0))
        else $error("two-codeword beat left bits behind");

endmodule

// File: hdl/hsd_back.sv
// Back end: corrects codewords, counts errors, pairs nibbles into result bytes.
module hsd_back #(
    parameter int ERROR_COUNT_BITS = hsd_pkg::HSD_ERROR_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsd_pkg::t_work    i_work,
    input  logic              i_work_valid,
    output logic              o_work_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output hsd_pkg::t_result  o_res
);
    import hsd_pkg::*;

    localparam int CNT_W = ERROR_COUNT_BITS;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]       r_held_nib, n_held_nib;
    logic             r_nib_wait, n_nib_wait;

    logic             w_go;
    logic [3:0]       w_nib0, w_nib1;
    logic             w_err0, w_err1;
    logic [1:0]       w_inc;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_cnt_sat;
    logic [63:0]      w_total_src;

    assign w_go       = i_work_valid && !i_res_full;
    assign o_work_pop = w_go;

    assign w_nib0 = hsd_correct(i_work.cw0);
    assign w_nib1 = hsd_correct(i_work.cw1);
    assign w_err0 = (hsd_syndrome(i_work.cw0) != 3'd0);
    assign w_err1 = i_work.two && (hsd_syndrome(i_work.cw1) != 3'd0);
    assign w_inc  = {1'b0, w_err0} + {1'b0, w_err1};

    // Saturate at all ones.
    assign w_sum     = {1'b0, r_cnt} + (CNT_W+1)'(w_inc);
    assign w_cnt_sat = w_sum[CNT_W] ? '1 : w_sum[CNT_W-1:0];

    always_comb begin
        n_cnt      = r_cnt;
        n_held_nib = r_held_nib;
        n_nib_wait = r_nib_wait;
        o_res_push = 1'b0;
        o_res.out_byte   = 8'd0;
        o_res.is_summary = 1'b0;
        w_total_src      = 64'(r_cnt);

        if (w_go) begin
            if (i_work.is_end) begin
                // Emit the summary beat, drop leftovers and clear.
                o_res_push       = 1'b1;
                o_res.is_summary = 1'b1;
                n_cnt      = '0;
                n_held_nib = 4'd0;
                n_nib_wait = 1'b0;
            end else begin
                n_cnt       = w_cnt_sat;
                w_total_src = 64'(w_cnt_sat);
                if (i_work.two) begin
                    o_res_push = 1'b1;
                    if (r_nib_wait) begin
                        o_res.out_byte = {r_held_nib, w_nib0};
                        n_held_nib     = w_nib1;
                        n_nib_wait     = 1'b1;
                    end else begin
                        o_res.out_byte = {w_nib0, w_nib1};
                        n_nib_wait     = 1'b0;
                    end
                end else if (r_nib_wait) begin
                    o_res_push     = 1'b1;
                    o_res.out_byte = {r_held_nib, w_nib0};
                    n_nib_wait     = 1'b0;
                end else begin
                    n_held_nib = w_nib0;
                    n_nib_wait = 1'b1;
                end
            end
        end
        o_res.error_total = w_total_src[HSD_TOTAL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_held_nib <= '0;
            r_nib_wait <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_held_nib <= n_held_nib;
            r_nib_wait <= n_nib_wait;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && i_work.is_end) |=> (r_cnt == '0 && !r_nib_wait))
        else $error("end marker did not clear state");

    a_clean_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !i_work.is_end && w_inc == 2'd0) |=> (r_cnt == $past(r_cnt)))
        else $error("error count moved on clean codewords");

    a_pair_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !i_work.is_end && (i_work.two || r_nib_wait)) |-> o_res_push)
        else $error("completed byte not emitted");

endmodule

// File: hdl/hamming_7_4_stream_decoder_unit.sv
// Top level of the Hamming (7,4) stream decoder with single-error correction.
//
// Input side is a queue: drive i_data_byte / i_end_of_data with push; a beat
// is taken at a rising edge with push high and full low. Result side is a
// queue too: while empty is low the oldest result sits on o_out_byte,
// o_error_total and o_is_summary, and it leaves at an edge with pop high.
// Each data byte carries one or two 7-bit codewords (MSB first); a result
// byte appears once two corrected nibbles are paired. An end-of-data beat
// yields a summary result with the error total and clears all state.
// Throughput is one input beat per cycle while the receiver keeps popping
// results; the back end decodes up to two codewords and updates the error
// counter for each work beat. An accepted beat enters the work queue at the
// accepting edge; the back end takes it from that queue's head while the
// result queue has room and writes its result, if any, into the result queue.
// Synchronous active-low reset empties both queues and clears the bit gather,
// nibble pairing and error counter. When the receiver stalls the result queue
// fills, the back end holds, the work queue fills and full rises.
module hamming_7_4_stream_decoder_unit #(
    parameter int ERROR_COUNT_BITS = hsd_pkg::HSD_ERROR_COUNT_BITS,
    parameter int QUEUE_DEPTH      = hsd_pkg::HSD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic [hsd_pkg::HSD_TOTAL_BITS-1:0] o_error_total,
    output logic        o_is_summary
);
    import hsd_pkg::*;

    localparam int WORK_W = $bits(t_work);
    localparam int RES_W  = $bits(t_result);

    logic    accept;
    t_work   front_work;
    t_work   queued_work;
    logic    work_empty;
    logic    work_pop;
    logic    res_full;
    logic    res_push;
    t_result back_res;
    t_result head_res;

    assign accept = push && !full;

    hsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_end_of_data(i_end_of_data),
        .o_work       (front_work)
    );

    hsd_fifo #(
        .WIDTH(WORK_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_work_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_work),
        .o_full (full),
        .i_pop  (work_pop),
        .o_data (queued_work),
        .o_empty(work_empty)
    );

    hsd_back #(
        .ERROR_COUNT_BITS(ERROR_COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (queued_work),
        .i_work_valid(!work_empty),
        .o_work_pop  (work_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    hsd_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (back_res),
        .o_full (res_full),
        .i_pop  (pop && !empty),
        .o_data (head_res),
        .o_empty(empty)
    );

    assign o_out_byte    = head_res.out_byte;
    assign o_error_total = head_res.error_total;
    assign o_is_summary  = head_res.is_summary;

endmodule

// File: tb/sv/hamming_7_4_stream_decoder_unit_tb.sv
// Self-checking testbench for the Hamming (7,4) stream decoder: predicts every result byte and summary.
`timescale 1ns / 1ps

module hamming_7_4_stream_decoder_unit_tb;

    import hsd_pkg::*;

    // Tracks the decoder state and holds the result beats still to come.
    class hamming_result_board;
        logic [13:0]  gather;
        int unsigned  held;
        logic [3:0]   first_nibble;
        bit           nibble_ready;
        logic [31:0]  error_count;
        t_result      expected_q[$];
        int unsigned  fails;

        function new();
            clear();
            fails = 0;
        endfunction

        function void clear();
            gather       = '0;
            held         = 0;
            first_nibble = '0;
            nibble_ready = 1'b0;
            error_count  = '0;
        endfunction

        // Codeword MSB is c0; bit cj contributes j+1.
        static function logic [2:0] syndrome(logic [6:0] w);
            logic [2:0] s;
            s = 3'd0;
            for (int j = 0; j < 7; j++) begin
                if (w[6-j]) begin
                    s = s ^ 3'(j + 1);
                end
            end
            return s;
        endfunction

        function void take_beat(logic [7:0] data, logic eod);
            t_result     r;
            logic [6:0]  word;
            logic [2:0]  syn;
            logic [3:0]  nib;
            bit          made_one;
            logic [7:0]  made;
            made_one = 1'b0;
            made     = '0;
            if (eod) begin
                r.out_byte    = 8'h00;
                r.error_total = error_count;
                r.is_summary  = 1'b1;
                expected_q.push_back(r);
                clear();
                return;
            end
            gather = {gather[5:0], data};
            held   = held + 8;
            while (held >= 7) begin
                word   = 7'(gather >> (held - 7));
                held   = held - 7;
                gather = gather & 14'((1 << held) - 1);
                syn    = syndrome(word);
                nib    = word[6:3];
                if (syn != 3'd0) begin
                    if (error_count != '1) begin
                        error_count = error_count + 1;
                    end
                    if (syn <= 3'd4) begin
                        nib = nib ^ (4'b1000 >> (syn - 1));
                    end
                end
                if (nibble_ready) begin
                    made         = {first_nibble, nib};
                    made_one     = 1'b1;
                    nibble_ready = 1'b0;
                    first_nibble = '0;
                end else begin
                    first_nibble = nib;
                    nibble_ready = 1'b1;
                end
            end
            if (made_one) begin
                r.out_byte    = made;
                r.error_total = error_count;
                r.is_summary  = 1'b0;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic [7:0] out_byte, logic [31:0] total, logic summary);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual byte %02h total %0d summary %0b",
                         $time, out_byte, total, summary);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (out_byte !== e.out_byte) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, e.out_byte, out_byte);
                fails++;
            end
            if (total !== e.error_total) begin
                $display("%0t: error_total mismatch: expected %0d, actual %0d",
                         $time, e.error_total, total);
                fails++;
            end
            if (summary !== e.is_summary) begin
                $display("%0t: is_summary mismatch: expected %0b, actual %0b",
                         $time, e.is_summary, summary);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_end_of_data;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic [HSD_TOTAL_BITS-1:0] o_error_total;
    logic        o_is_summary;

    hamming_result_board board;
    int unsigned         send_idle;
    int unsigned         recv_stall;
    int unsigned         beats_sent;
    bit                  stream_bits[$];

    hamming_7_4_stream_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_end_of_data (i_end_of_data),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_error_total (o_error_total),
        .o_is_summary  (o_is_summary)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99, 0) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_result(o_out_byte, o_error_total, o_is_summary);
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic eod);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_data_byte   <= data;
        i_end_of_data <= eod;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        board.take_beat(data, eod);
        beats_sent++;
    endtask

    // Drop push and hold until every expected beat has been popped.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [6:0] encode_nibble(logic [3:0] data);
        logic [6:0] w;
        w = {data, 3'b000};
        for (int p = 0; p < 8; p++) begin
            w = {data, 3'(p)};
            if (hamming_result_board::syndrome(w) == 3'd0) begin
                return w;
            end
        end
        return w;
    endfunction

    task automatic append_word(input logic [6:0] w);
        for (int i = 6; i >= 0; i--) begin
            stream_bits.push_back(w[i]);
        end
    endtask

    // Pack queued bits MSB first; pad the last beat with random bits.
    task automatic flush_stream();
        logic [7:0] b;
        while (stream_bits.size() > 0) begin
            b = 8'($urandom);
            for (int i = 7; i >= 0; i--) begin
                if (stream_bits.size() > 0) begin
                    b[i] = stream_bits.pop_front();
                end
            end
            send_beat(b, 1'b0);
        end
    endtask

    task automatic send_frame();
        int         n_words;
        int         roll;
        int         pos;
        logic [6:0] w;
        n_words = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        for (int k = 0; k < n_words; k++) begin
            w    = encode_nibble(4'($urandom));
            roll = $urandom_range(99, 0);
            pos  = $urandom_range(6, 0);
            if (roll < 30) begin
                w[pos] = ~w[pos];
            end else if (roll < 40) begin
                w[pos] = ~w[pos];
                pos = (pos + $urandom_range(6, 1)) % 7;
                w[pos] = ~w[pos];
            end
            append_word(w);
        end
        flush_stream();
        if ($urandom_range(99, 0) < 85) begin
            send_beat(8'($urandom), 1'b1);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(12, 1);
        for (int k = 0; k < n; k++) begin
            send_beat(8'($urandom), ($urandom_range(9, 0) == 0));
        end
    endtask

    initial begin
        int unsigned idle_of[4];
        int unsigned stall_of[4];
        int unsigned phase_end;
        logic [6:0]  w;
        idle_of  = '{0, 59, 0, 24};
        stall_of = '{0, 0, 59, 24};
        board         = new();
        send_idle     = 0;
        recv_stall    = 0;
        beats_sent    = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_data_byte   = 8'h00;
        i_end_of_data = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // End marker straight after reset: empty summary.
        send_beat(8'hFF, 1'b1);
        // One clean word, then every single-bit flip: syndromes zero through seven.
        append_word(encode_nibble(4'hA));
        for (int i = 0; i < 7; i++) begin
            w = encode_nibble(4'h5);
            w[6-i] = ~w[6-i];
            append_word(w);
        end
        flush_stream();
        send_beat(8'h00, 1'b1);
        // All-ones and all-zero beats leave four bits over; end drops them.
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        // A lone nibble waiting at the end is dropped.
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = idle_of[ph];
            recv_stall = stall_of[ph];
            phase_end  = beats_sent + 262;
            while (beats_sent < phase_end) begin
                if ($urandom_range(99, 0) < 80) begin
                    send_frame();
                end else begin
                    send_noise();
                end
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (board.fails == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
